// File: hdl/lpht_pkg.sv
// Shared codes and default sizes for the linear-probe hash table.
// No dependencies; lpht_mod, the top level and lpht_chk import this package.
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_VALUE_BITS  = 32;

  localparam int FIELD_BITS = 32;
  localparam int HASH_BITS  = 32;
  localparam int CFG_BITS   = 11;

  localparam logic [CFG_BITS-1:0] CFG_RESET_LEN = 11'd1024;

  // commands
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_UPDATE = 3'd1;
  localparam logic [2:0] CMD_CHANGE = 3'd2;
  localparam logic [2:0] CMD_SEARCH = 3'd3;
  localparam logic [2:0] CMD_EXISTS = 3'd4;
  localparam logic [2:0] CMD_REMOVE = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;
  localparam logic [2:0] CMD_NOP    = 3'd7;

  // result status
  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_NOTFOUND = 2'd1;
  localparam logic [1:0] RES_FULL     = 2'd2;

  // slot state
  localparam logic [1:0] SL_EMPTY = 2'd0;
  localparam logic [1:0] SL_LIVE  = 2'd1;
  localparam logic [1:0] SL_DEAD  = 2'd2;

endpackage
`default_nettype wire

// File: hdl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/lpht_mod.sv
// Bit-serial remainder unit: hash mod table length, one dividend bit a cycle.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpht_mod #(
  parameter int LW = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           go,
  input  wire logic [lpht_pkg::HASH_BITS-1:0] dvd,
  input  wire logic [LW-1:0]                  dsr,
  output logic                                done,
  output logic      [LW-1:0]                  rem
);
  import lpht_pkg::*;

  localparam int CW = $clog2(HASH_BITS);

  logic                 busy_r, done_r;
  logic [CW-1:0]        cnt_r;
  logic [HASH_BITS-1:0] dvd_r;
  logic [LW-1:0]        dsr_r, rem_r, rem_nxt;
  logic [LW:0]          sh, diff;

  always_comb begin
    sh      = {rem_r, dvd_r[HASH_BITS-1]};
    diff    = sh - {1'b0, dsr_r};
    rem_nxt = (sh >= {1'b0, dsr_r}) ? diff[LW-1:0] : sh[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0) && !go;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
    if (go) begin
      dvd_r <= dvd;
      dsr_r <= dsr;
      rem_r <= '0;
      cnt_r <= CW'(HASH_BITS - 1);
    end else if (busy_r) begin
      dvd_r <= {dvd_r[HASH_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: hdl/linear_probe_hash_table.sv
// Open-addressing key/value table with linear probing, top level.
// Depends on lpht_pkg, lpht_ram and lpht_mod.
//
// One command at a time. Every command but clear and nop first reduces its
// hash modulo the table length in the bit-serial remainder unit, then probes
// one slot at a time through the slot RAM read port, each probe taking a wait
// state and a compare state; placing and removing an entry add linked-list
// fix-ups. Clear and a table_length write sweep the slot RAM, one slot a
// cycle over the effective table length (also after reset, with the reset
// length of min(1024, TABLE_DEPTH)); in_stall is high during the sweep.
// An insert, or an update that misses, that would leave no empty slot while
// deleted slots exist compacts the table: a walk of the insertion-order chain
// into a scratch RAM, a sweep, then one full insert per live entry.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = lpht_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = lpht_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = lpht_pkg::DEF_VALUE_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [2:0]                      in_command,
  input  wire logic [lpht_pkg::FIELD_BITS-1:0] in_key,
  input  wire logic [lpht_pkg::FIELD_BITS-1:0] in_hash_value,
  input  wire logic [lpht_pkg::FIELD_BITS-1:0] in_value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [1:0]                      out_status,
  output logic                                 out_found,
  output logic      [lpht_pkg::FIELD_BITS-1:0] out_old_key,
  output logic      [lpht_pkg::FIELD_BITS-1:0] out_value_out,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lpht_pkg::CFG_BITS-1:0]   cfg_table_length
);
  import lpht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
  localparam int VW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
  localparam int RW = 2 + KW + VW + HASH_BITS + 2 * LW;
  localparam int SW = KW + VW + HASH_BITS;
  localparam logic [LW-1:0] NONE = LW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_PW   = 4'd3;
  localparam logic [3:0] S_PC   = 4'd4;
  localparam logic [3:0] S_LNK  = 4'd5;
  localparam logic [3:0] S_LW   = 4'd6;
  localparam logic [3:0] S_LC   = 4'd7;
  localparam logic [3:0] S_CWK  = 4'd8;
  localparam logic [3:0] S_CW   = 4'd9;
  localparam logic [3:0] S_CC   = 4'd10;
  localparam logic [3:0] S_SR   = 4'd11;
  localparam logic [3:0] S_SW   = 4'd12;
  localparam logic [3:0] S_SC   = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  localparam logic [1:0] POST_IDLE  = 2'd0;
  localparam logic [1:0] POST_DONE  = 2'd1;
  localparam logic [1:0] POST_REINS = 2'd2;

  function automatic logic [LW-1:0] eff_len(input logic [CFG_BITS-1:0] raw);
    logic [31:0] v;
    v = 32'(raw);
    if (v < 32'd2) v = 32'd2;
    if (v > 32'(TABLE_DEPTH)) v = 32'(TABLE_DEPTH);
    return v[LW-1:0];
  endfunction

  // control
  logic [3:0]    state_r, state_nxt;
  logic [1:0]    post_r, post_nxt;
  logic [LW-1:0] len_r, len_nxt, live_r, live_nxt, dead_r, dead_nxt;
  logic [LW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [LW-1:0] clr_r, clr_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] cur_r, cur_nxt, n_r, n_nxt, k_r, k_nxt;
  logic [AW-1:0] idx_r, idx_nxt, home_r, home_nxt;
  logic          free_r, free_nxt, cmp_r, cmp_nxt, ins_r, ins_nxt;
  logic          fn_v_r, fn_v_nxt, fp_v_r, fp_v_nxt, lsel_r, lsel_nxt;
  logic [AW-1:0] fn_a_r, fn_a_nxt, fp_a_r, fp_a_nxt;
  logic [LW-1:0] fn_d_r, fn_d_nxt, fp_d_r, fp_d_nxt;

  // item and working operands
  logic [2:0]           it_cmd_r, it_cmd_nxt;
  logic [KW-1:0]        it_key_r, it_key_nxt, wk_key_r, wk_key_nxt;
  logic [VW-1:0]        it_val_r, it_val_nxt, wk_val_r, wk_val_nxt;
  logic [HASH_BITS-1:0] it_hash_r, it_hash_nxt, wk_hash_r, wk_hash_nxt;

  // result and output register
  logic [1:0]      res_st_r, res_st_nxt;
  logic            res_fd_r, res_fd_nxt;
  logic [KW-1:0]   res_ok_r, res_ok_nxt;
  logic [VW-1:0]   res_vo_r, res_vo_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_st_r, out_st_nxt;
  logic            out_fd_r, out_fd_nxt;
  logic [FIELD_BITS-1:0] out_ok_r, out_ok_nxt, out_vo_r, out_vo_nxt;

  // memories
  logic          s_we;
  logic [AW-1:0] s_wa;
  logic [RW-1:0] s_wd, s_rd;
  logic          x_we;
  logic [SW-1:0] x_wd, x_rd;

  logic [1:0]           rd_st;
  logic [KW-1:0]        rd_key;
  logic [VW-1:0]        rd_val;
  logic [HASH_BITS-1:0] rd_hash;
  logic [LW-1:0]        rd_prev, rd_next;

  logic                 div_go, div_done;
  logic [HASH_BITS-1:0] div_dvd;
  logic [LW-1:0]        div_rem;

  logic          need_room, last, cfg_hit;
  logic [AW-1:0] idx_step;

  assign rd_st   = s_rd[RW-1 -: 2];
  assign rd_key  = s_rd[RW-3 -: KW];
  assign rd_val  = s_rd[RW-3-KW -: VW];
  assign rd_hash = s_rd[2*LW+HASH_BITS-1 -: HASH_BITS];
  assign rd_prev = s_rd[2*LW-1 -: LW];
  assign rd_next = s_rd[LW-1:0];

  assign need_room = ((LW+1)'(live_r) + (LW+1)'(dead_r) + (LW+1)'(1)) >= (LW+1)'(len_r);
  assign last      = (cnt_r + LW'(1)) == len_r;
  assign idx_step  = ((LW'(idx_r) + LW'(1)) == len_r) ? '0 : idx_r + AW'(1);

  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLR && post_r == POST_IDLE);
  assign cfg_hit   = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;

  always_comb begin
    state_nxt = state_r;   post_nxt = post_r;   len_nxt = len_r;
    live_nxt = live_r;     dead_nxt = dead_r;   head_nxt = head_r;   tail_nxt = tail_r;
    clr_nxt = clr_r;       cnt_nxt = cnt_r;     cur_nxt = cur_r;     n_nxt = n_r;
    k_nxt = k_r;           idx_nxt = idx_r;     home_nxt = home_r;
    free_nxt = free_r;     cmp_nxt = cmp_r;     ins_nxt = ins_r;
    fn_v_nxt = fn_v_r;     fn_a_nxt = fn_a_r;   fn_d_nxt = fn_d_r;
    fp_v_nxt = fp_v_r;     fp_a_nxt = fp_a_r;   fp_d_nxt = fp_d_r;   lsel_nxt = lsel_r;
    it_cmd_nxt = it_cmd_r; it_key_nxt = it_key_r; it_val_nxt = it_val_r;
    it_hash_nxt = it_hash_r;
    wk_key_nxt = wk_key_r; wk_val_nxt = wk_val_r; wk_hash_nxt = wk_hash_r;
    res_st_nxt = res_st_r; res_fd_nxt = res_fd_r; res_ok_nxt = res_ok_r;
    res_vo_nxt = res_vo_r;
    out_valid_nxt = out_valid_r; out_st_nxt = out_st_r; out_fd_nxt = out_fd_r;
    out_ok_nxt = out_ok_r; out_vo_nxt = out_vo_r;
    s_we = 1'b0; s_wa = idx_r; s_wd = '0;
    x_we = 1'b0; x_wd = {rd_key, rd_val, rd_hash};
    div_go = 1'b0; div_dvd = wk_hash_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cfg_hit) begin
      len_nxt = eff_len(cfg_table_length);
      clr_nxt = '0; live_nxt = '0; dead_nxt = '0; head_nxt = NONE; tail_nxt = NONE;
      post_nxt = POST_IDLE;
      state_nxt = S_CLR;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            it_cmd_nxt  = in_command;
            it_key_nxt  = in_key[KW-1:0];
            it_val_nxt  = in_value[VW-1:0];
            it_hash_nxt = in_hash_value;
            wk_key_nxt  = in_key[KW-1:0];
            wk_val_nxt  = in_value[VW-1:0];
            wk_hash_nxt = in_hash_value;
            res_st_nxt = RES_OK; res_fd_nxt = 1'b0; res_ok_nxt = '0; res_vo_nxt = '0;
            ins_nxt = 1'b0; cmp_nxt = 1'b0;
            if (in_command == CMD_CLEAR) begin
              clr_nxt = '0; live_nxt = '0; dead_nxt = '0; head_nxt = NONE; tail_nxt = NONE;
              post_nxt = POST_DONE;
              state_nxt = S_CLR;
            end else if (in_command == CMD_NOP) begin
              state_nxt = S_DONE;
            end else begin
              div_go = 1'b1; div_dvd = in_hash_value;
              state_nxt = S_DIV;
            end
          end
        end
        S_CLR: begin
          s_we = 1'b1; s_wa = clr_r[AW-1:0]; s_wd = '0;
          clr_nxt = clr_r + LW'(1);
          if ((clr_r + LW'(1)) == len_r) begin
            unique case (post_r)
              POST_DONE:  state_nxt = S_DONE;
              POST_REINS: begin k_nxt = '0; state_nxt = S_SR; end
              default:    state_nxt = S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            idx_nxt = div_rem[AW-1:0]; home_nxt = div_rem[AW-1:0]; cnt_nxt = '0;
            if (cmp_r || ins_r) begin
              free_nxt = 1'b1; state_nxt = S_PW;
            end else if (it_cmd_r == CMD_INSERT) begin
              if (!need_room) begin
                free_nxt = 1'b1; state_nxt = S_PW;
              end else if (dead_r != '0) begin
                ins_nxt = 1'b1; cur_nxt = head_r; n_nxt = '0; state_nxt = S_CWK;
              end else begin
                res_st_nxt = RES_FULL; state_nxt = S_DONE;
              end
            end else begin
              free_nxt = 1'b0; state_nxt = S_PW;
            end
          end
        end
        S_PW: state_nxt = S_PC;
        S_PC: begin
          if (free_r) begin
            if (rd_st != SL_LIVE) begin
              // place the entry and append it to the insertion chain
              s_we = 1'b1;
              s_wd = {SL_LIVE, wk_key_r, wk_val_r, wk_hash_r, tail_r, NONE};
              if (rd_st == SL_DEAD && dead_r != '0) dead_nxt = dead_r - LW'(1);
              live_nxt = live_r + LW'(1);
              if (tail_r != NONE) begin
                fn_v_nxt = 1'b1; fn_a_nxt = tail_r[AW-1:0]; fn_d_nxt = LW'(idx_r);
              end else begin
                head_nxt = LW'(idx_r);
              end
              tail_nxt = LW'(idx_r);
              state_nxt = S_LNK;
            end else if (last) begin
              if (cmp_r) begin
                k_nxt = k_r + LW'(1); state_nxt = S_SR;
              end else begin
                res_st_nxt = RES_FULL; state_nxt = S_DONE;
              end
            end else begin
              idx_nxt = idx_step; cnt_nxt = cnt_r + LW'(1); state_nxt = S_PW;
            end
          end else if (rd_st == SL_LIVE && rd_key == wk_key_r) begin
            res_fd_nxt = 1'b1;
            state_nxt = S_DONE;
            unique case (it_cmd_r)
              CMD_UPDATE: begin
                s_we = 1'b1;
                s_wd = {SL_LIVE, wk_key_r, wk_val_r, wk_hash_r, rd_prev, rd_next};
                res_ok_nxt = rd_key; res_vo_nxt = rd_val;
              end
              CMD_CHANGE: begin
                s_we = 1'b1;
                s_wd = {rd_st, rd_key, wk_val_r, rd_hash, rd_prev, rd_next};
                res_vo_nxt = rd_val;
              end
              CMD_SEARCH: res_vo_nxt = rd_val;
              CMD_REMOVE: begin
                // tombstone the slot and unlink it from the chain
                s_we = 1'b1;
                s_wd = {SL_DEAD, {KW{1'b0}}, {VW{1'b0}}, rd_hash, NONE, NONE};
                res_vo_nxt = rd_val;
                if (rd_prev != NONE) begin
                  fn_v_nxt = 1'b1; fn_a_nxt = rd_prev[AW-1:0]; fn_d_nxt = rd_next;
                end else begin
                  head_nxt = rd_next;
                end
                if (rd_next != NONE) begin
                  fp_v_nxt = 1'b1; fp_a_nxt = rd_next[AW-1:0]; fp_d_nxt = rd_prev;
                end else begin
                  tail_nxt = rd_prev;
                end
                if (live_r != '0) live_nxt = live_r - LW'(1);
                dead_nxt = dead_r + LW'(1);
                state_nxt = S_LNK;
              end
              default: ;
            endcase
          end else if (rd_st == SL_EMPTY || last) begin
            if (it_cmd_r == CMD_UPDATE) begin
              if (!need_room) begin
                free_nxt = 1'b1; idx_nxt = home_r; cnt_nxt = '0; state_nxt = S_PW;
              end else if (dead_r != '0) begin
                ins_nxt = 1'b1; cur_nxt = head_r; n_nxt = '0; state_nxt = S_CWK;
              end else begin
                res_st_nxt = RES_FULL; state_nxt = S_DONE;
              end
            end else begin
              res_st_nxt = RES_NOTFOUND; state_nxt = S_DONE;
            end
          end else begin
            idx_nxt = idx_step; cnt_nxt = cnt_r + LW'(1); state_nxt = S_PW;
          end
        end
        S_LNK: begin
          if (fn_v_r) begin
            idx_nxt = fn_a_r; lsel_nxt = 1'b0; state_nxt = S_LW;
          end else if (fp_v_r) begin
            idx_nxt = fp_a_r; lsel_nxt = 1'b1; state_nxt = S_LW;
          end else if (cmp_r) begin
            k_nxt = k_r + LW'(1); state_nxt = S_SR;
          end else begin
            state_nxt = S_DONE;
          end
        end
        S_LW: state_nxt = S_LC;
        S_LC: begin
          s_we = 1'b1;
          if (!lsel_r) begin
            s_wd = {rd_st, rd_key, rd_val, rd_hash, rd_prev, fn_d_r};
            fn_v_nxt = 1'b0;
          end else begin
            s_wd = {rd_st, rd_key, rd_val, rd_hash, fp_d_r, rd_next};
            fp_v_nxt = 1'b0;
          end
          state_nxt = S_LNK;
        end
        S_CWK: begin
          if (cur_r == NONE) begin
            clr_nxt = '0; live_nxt = '0; dead_nxt = '0; head_nxt = NONE; tail_nxt = NONE;
            post_nxt = POST_REINS; cmp_nxt = 1'b1;
            state_nxt = S_CLR;
          end else begin
            idx_nxt = cur_r[AW-1:0]; state_nxt = S_CW;
          end
        end
        S_CW: state_nxt = S_CC;
        S_CC: begin
          x_we = 1'b1;
          n_nxt = n_r + LW'(1);
          cur_nxt = rd_next;
          state_nxt = S_CWK;
        end
        S_SR: begin
          if (k_r == n_r) begin
            // compaction over: resume the pending insert
            cmp_nxt = 1'b0;
            wk_key_nxt = it_key_r; wk_val_nxt = it_val_r; wk_hash_nxt = it_hash_r;
            div_go = 1'b1; div_dvd = it_hash_r;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_SW;
          end
        end
        S_SW: state_nxt = S_SC;
        S_SC: begin
          wk_key_nxt  = x_rd[SW-1 -: KW];
          wk_val_nxt  = x_rd[HASH_BITS+VW-1 -: VW];
          wk_hash_nxt = x_rd[HASH_BITS-1:0];
          div_go = 1'b1; div_dvd = x_rd[HASH_BITS-1:0];
          state_nxt = S_DIV;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_nxt = 1'b1;
            out_st_nxt = res_st_r;
            out_fd_nxt = res_fd_r;
            out_ok_nxt = FIELD_BITS'(res_ok_r);
            out_vo_nxt = FIELD_BITS'(res_vo_r);
            state_nxt = S_IDLE;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      post_r <= POST_IDLE;
      len_r <= eff_len(CFG_RESET_LEN);
      live_r <= '0; dead_r <= '0; head_r <= NONE; tail_r <= NONE;
      clr_r <= '0;
      cmp_r <= 1'b0; ins_r <= 1'b0;
      fn_v_r <= 1'b0; fp_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      post_r <= post_nxt;
      len_r <= len_nxt;
      live_r <= live_nxt; dead_r <= dead_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
      clr_r <= clr_nxt;
      cmp_r <= cmp_nxt; ins_r <= ins_nxt;
      fn_v_r <= fn_v_nxt; fp_v_r <= fp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r <= cnt_nxt; cur_r <= cur_nxt; n_r <= n_nxt; k_r <= k_nxt;
    idx_r <= idx_nxt; home_r <= home_nxt; free_r <= free_nxt; lsel_r <= lsel_nxt;
    fn_a_r <= fn_a_nxt; fn_d_r <= fn_d_nxt; fp_a_r <= fp_a_nxt; fp_d_r <= fp_d_nxt;
    it_cmd_r <= it_cmd_nxt; it_key_r <= it_key_nxt; it_val_r <= it_val_nxt;
    it_hash_r <= it_hash_nxt;
    wk_key_r <= wk_key_nxt; wk_val_r <= wk_val_nxt; wk_hash_r <= wk_hash_nxt;
    res_st_r <= res_st_nxt; res_fd_r <= res_fd_nxt; res_ok_r <= res_ok_nxt;
    res_vo_r <= res_vo_nxt;
    out_st_r <= out_st_nxt; out_fd_r <= out_fd_nxt; out_ok_r <= out_ok_nxt;
    out_vo_r <= out_vo_nxt;
  end

  lpht_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_wa),
    .wdata (s_wd),
    .raddr (idx_r),
    .rdata (s_rd)
  );

  // holds live entries in chain order during compaction
  lpht_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_scratch (
    .clk   (clk),
    .we    (x_we),
    .waddr (n_r[AW-1:0]),
    .wdata (x_wd),
    .raddr (k_r[AW-1:0]),
    .rdata (x_rd)
  );

  lpht_mod #(.LW(LW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .dvd   (div_dvd),
    .dsr   (len_r),
    .done  (div_done),
    .rem   (div_rem)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_st_r;
  assign out_found     = out_fd_r;
  assign out_old_key   = out_ok_r;
  assign out_value_out = out_vo_r;

endmodule
`default_nettype wire

// File: hdl/lpht_chk.sv
// Port-level checks for linear_probe_hash_table, attached with bind.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpht_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [1:0]                      out_status,
  input wire logic                            out_found,
  input wire logic [lpht_pkg::FIELD_BITS-1:0] out_old_key,
  input wire logic [lpht_pkg::FIELD_BITS-1:0] out_value_out,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready
);
  import lpht_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_old_key) && $stable(out_value_out))
    else $error("stalled result beat changed");

  // the store is swept after reset before any command is taken
  a_sweep: assert property (@(posedge clk) disable iff (!rst_n) $past(!rst_n) |-> in_stall)
    else $error("command taken during reset sweep");

  // hold off commands while a configuration beat is offered
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> in_stall)
    else $error("command taken beside a configuration beat");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == RES_OK)
    else $error("found with failing status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != RES_OK |-> out_old_key == '0 && out_value_out == '0)
    else $error("failing result carries data");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (.*);
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for linear_probe_hash_table: random and directed commands
// against an in-bench table predictor. Depends on lpht_pkg and the RTL in hdl/.
`timescale 1ns / 1ps
module tb_top;
  import lpht_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int NONE  = DEPTH;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [31:0] hash;
    logic [31:0] value;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] old_key;
    logic [31:0] value_out;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = CMD_NOP;
  logic [31:0] in_key = '0, in_hash_value = '0, in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic out_found;
  logic [31:0] out_old_key, out_value_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_BITS-1:0] cfg_table_length = CFG_RESET_LEN;

  linear_probe_hash_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_key(in_key), .in_hash_value(in_hash_value), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_found(out_found), .out_old_key(out_old_key), .out_value_out(out_value_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_table_length(cfg_table_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- table predictor ----------------
  logic [1:0]  slot_st [DEPTH];
  logic [31:0] slot_k [DEPTH];
  logic [31:0] slot_v [DEPTH];
  logic [31:0] slot_h [DEPTH];
  int unsigned link_prev [DEPTH];
  int unsigned link_next [DEPTH];
  int unsigned head_slot, tail_slot, live_n, dead_n;
  logic [CFG_BITS-1:0] len_reg;

  function automatic int unsigned span();
    if (len_reg < 2) return 2;
    if (len_reg > DEPTH) return DEPTH;
    return len_reg;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < DEPTH; i++) slot_st[i] = SL_EMPTY;
    head_slot = NONE;
    tail_slot = NONE;
    live_n = 0;
    dead_n = 0;
  endfunction

  function automatic void link_append(int unsigned i);
    link_prev[i] = tail_slot;
    link_next[i] = NONE;
    if (tail_slot < NONE) link_next[tail_slot] = i;
    else head_slot = i;
    tail_slot = i;
  endfunction

  function automatic void link_unhook(int unsigned i);
    int unsigned p, n;
    p = link_prev[i];
    n = link_next[i];
    if (p < NONE) link_next[p] = n;
    else head_slot = n;
    if (n < NONE) link_prev[n] = p;
    else tail_slot = p;
  endfunction

  function automatic bit probe_match(logic [31:0] k, logic [31:0] h, output int unsigned at);
    int unsigned i, n;
    n = span();
    i = h % n;
    at = 0;
    for (int s = 0; s < n; s++) begin
      if (slot_st[i] == SL_EMPTY) return 0;
      if (slot_st[i] == SL_LIVE && slot_k[i] == k) begin
        at = i;
        return 1;
      end
      i = (i + 1 >= n) ? 0 : i + 1;
    end
    return 0;
  endfunction

  function automatic bit probe_free(logic [31:0] h, output int unsigned at);
    int unsigned i, n;
    n = span();
    i = h % n;
    at = 0;
    for (int s = 0; s < n; s++) begin
      if (slot_st[i] != SL_LIVE) begin
        at = i;
        return 1;
      end
      i = (i + 1 >= n) ? 0 : i + 1;
    end
    return 0;
  endfunction

  function automatic void put_entry(int unsigned i, logic [31:0] k, logic [31:0] v,
                                    logic [31:0] h);
    if (slot_st[i] == SL_DEAD && dead_n > 0) dead_n--;
    slot_k[i] = k;
    slot_v[i] = v;
    slot_h[i] = h;
    slot_st[i] = SL_LIVE;
    link_append(i);
    live_n++;
  endfunction

  // rebuild the table from the insertion-order chain, dropping tombstones
  function automatic void repack();
    logic [31:0] kq[$], vq[$], hq[$];
    int unsigned cur, at;
    cur = head_slot;
    while (cur < NONE) begin
      kq.push_back(slot_k[cur]);
      vq.push_back(slot_v[cur]);
      hq.push_back(slot_h[cur]);
      cur = link_next[cur];
    end
    wipe_table();
    foreach (kq[j]) if (probe_free(hq[j], at)) put_entry(at, kq[j], vq[j], hq[j]);
  endfunction

  function automatic bit add_entry(logic [31:0] k, logic [31:0] v, logic [31:0] h);
    int unsigned at;
    if (live_n + dead_n + 1 >= span()) begin
      if (dead_n > 0) repack();
      else return 0;
    end
    if (!probe_free(h, at)) return 0;
    put_entry(at, k, v, h);
    return 1;
  endfunction

  function automatic reply_t apply_command(cmd_beat_t c);
    reply_t r;
    int unsigned at;
    r = '0;
    case (c.cmd)
      CMD_INSERT: if (!add_entry(c.key, c.value, c.hash)) r.status = RES_FULL;
      CMD_UPDATE: begin
        if (probe_match(c.key, c.hash, at)) begin
          r.found = 1'b1;
          r.old_key = slot_k[at];
          r.value_out = slot_v[at];
          slot_k[at] = c.key;
          slot_v[at] = c.value;
          slot_h[at] = c.hash;
        end else if (!add_entry(c.key, c.value, c.hash)) begin
          r.status = RES_FULL;
        end
      end
      CMD_CHANGE, CMD_SEARCH, CMD_EXISTS, CMD_REMOVE: begin
        if (!probe_match(c.key, c.hash, at)) begin
          r.status = RES_NOTFOUND;
        end else begin
          r.found = 1'b1;
          if (c.cmd != CMD_EXISTS) r.value_out = slot_v[at];
          if (c.cmd == CMD_CHANGE) slot_v[at] = c.value;
          if (c.cmd == CMD_REMOVE) begin
            link_unhook(at);
            slot_st[at] = SL_DEAD;
            if (live_n > 0) live_n--;
            dead_n++;
          end
        end
      end
      CMD_CLEAR: wipe_table();
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- stimulus ----------------
  cmd_beat_t pending_cmds[$];
  reply_t    expected_replies[$];
  logic [31:0] pool_key[16], pool_hash[16];
  int pool_n;
  int n_accepted = 0, n_checked = 0, n_hits = 0, n_full = 0, n_bad = 0;

  function automatic void refill_pool(int n);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = $urandom;
    end
  endfunction

  function automatic cmd_beat_t random_command();
    cmd_beat_t c;
    int p, w;
    p = $urandom_range(0, pool_n - 1);
    w = $urandom_range(0, 99);
    c.cmd = w < 25 ? CMD_INSERT : w < 40 ? CMD_UPDATE : w < 50 ? CMD_CHANGE :
            w < 65 ? CMD_SEARCH : w < 75 ? CMD_EXISTS : w < 95 ? CMD_REMOVE :
            w < 97 ? CMD_CLEAR : CMD_NOP;
    c.key = ($urandom_range(0, 9) == 0) ? $urandom : pool_key[p];
    c.hash = ($urandom_range(0, 6) == 0) ? $urandom : pool_hash[p];
    c.value = $urandom;
    return c;
  endfunction

  function automatic void queue_cmd(logic [2:0] cmd, logic [31:0] k, logic [31:0] h,
                                    logic [31:0] v);
    cmd_beat_t c;
    c.cmd = cmd;
    c.key = k;
    c.hash = h;
    c.value = v;
    pending_cmds.push_back(c);
  endfunction

  // driver: bursts of random length separated by random gaps
  int burst_left = 4, gap_left = 0;
  cmd_beat_t cur_cmd;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(apply_command(cur_cmd));
        n_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_command <= cur_cmd.cmd;
          in_key <= cur_cmd.key;
          in_hash_value <= cur_cmd.hash;
          in_value <= cur_cmd.value;
          if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks reply beats under a randomly redrawn stall pattern
  int stall_mode = 0, stall_tick = 0;
  always @(posedge clk) begin
    reply_t got, want;
    if (++stall_tick % 64 == 0) stall_mode = $urandom_range(0, 2);
    out_stall <= stall_mode == 0 ? 1'b0 :
                 stall_mode == 1 ? ($urandom_range(0, 9) < 3) : ($urandom_range(0, 9) < 7);
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_found, out_old_key, out_value_out};
      if (expected_replies.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected reply beat: %p", got);
      end else begin
        want = expected_replies.pop_front();
        n_checked++;
        if (want.found) n_hits++;
        if (want.status == RES_FULL) n_full++;
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch #%0d: exp st=%0d f=%0d ok=%h v=%h  got st=%0d f=%0d ok=%h v=%h",
                     n_checked, want.status, want.found, want.old_key, want.value_out,
                     got.status, got.found, got.old_key, got.value_out);
        end
      end
    end
  end

  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_length(logic [CFG_BITS-1:0] len);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_table_length <= len;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_reg = len;
    wipe_table();
  endtask

  initial begin
    logic [CFG_BITS-1:0] lengths[9] = '{11'd8, 11'd2, 11'd0, 11'd2047, 11'd5, 11'd16,
                                        11'd64, 11'd3, 11'd1024};
    int counts[9] = '{55, 45, 55, 25, 50, 55, 55, 45, 45};
    len_reg = CFG_RESET_LEN;
    wipe_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every command, field extremes, misses, nop
    queue_cmd(CMD_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF);
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    queue_cmd(CMD_INSERT, 32'h5, 32'h0, 32'h1234_5678);
    queue_cmd(CMD_SEARCH, 32'h5, 32'h0, 32'h0);
    queue_cmd(CMD_EXISTS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    queue_cmd(CMD_CHANGE, 32'h0, 32'h0, 32'hA5A5_5A5A);
    queue_cmd(CMD_UPDATE, 32'h5, 32'h0, 32'h7);
    queue_cmd(CMD_UPDATE, 32'h99, 32'h3FF, 32'h8);
    queue_cmd(CMD_REMOVE, 32'h0, 32'h0, 32'h0);
    queue_cmd(CMD_SEARCH, 32'h0, 32'h0, 32'h0);
    queue_cmd(CMD_CHANGE, 32'h0, 32'h0, 32'h1);
    queue_cmd(CMD_EXISTS, 32'h1234, 32'h7, 32'h0);
    queue_cmd(CMD_REMOVE, 32'h1234, 32'h7, 32'h0);
    queue_cmd(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
    queue_cmd(CMD_SEARCH, 32'h5, 32'h0, 32'h0);
    drain();

    // length 2: fill check refuses, then compaction after a remove
    set_length(11'd2);
    queue_cmd(CMD_INSERT, 32'h11, 32'h1, 32'h1);
    queue_cmd(CMD_INSERT, 32'h22, 32'h0, 32'h2);
    queue_cmd(CMD_UPDATE, 32'h33, 32'h0, 32'h3);
    queue_cmd(CMD_REMOVE, 32'h11, 32'h1, 32'h0);
    queue_cmd(CMD_INSERT, 32'h22, 32'h0, 32'h4);
    queue_cmd(CMD_SEARCH, 32'h22, 32'h0, 32'h0);
    drain();

    foreach (lengths[p]) begin
      set_length(lengths[p]);
      refill_pool((lengths[p] > 14 || lengths[p] < 2) ? 16 : lengths[p] + 2);
      repeat (counts[p]) pending_cmds.push_back(random_command());
      drain();
    end

    repeat (50) @(posedge clk);
    $display("checked %0d reply beats over %0d table lengths: %0d hits, %0d refused as full",
             n_checked, 11, n_hits, n_full);
    if (n_bad == 0 && expected_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d replies missing", n_bad, expected_replies.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout after %0d accepted commands", n_accepted);
    $display("FAILURE");
    $finish;
  end

endmodule
